/* sv/srle_pkg.sv */
`timescale 1ns / 1ps

package srle_pkg;

    localparam int PIX_W  = 8;
    localparam int RUN_W  = 13;
    localparam int LEN_W  = 16;
    localparam int CNT_W  = 7;
    localparam int CFG_W  = 13;
    localparam int Q_AW   = 2;
    localparam int Q_DEPTH = 1 << Q_AW;

    localparam logic [PIX_W-1:0] PKT_MARK = 8'h80;

    localparam logic [0:0] CFG_LINE_WIDTH = 1'b0;
    localparam logic [0:0] CFG_LINE_TOTAL = 1'b1;

    typedef enum logic [2:0] {
        PH_LEN_LO    = 3'd0,
        PH_LEN_HI    = 3'd1,
        PH_HEADER    = 3'd2,
        PH_RUN_VALUE = 3'd3,
        PH_LITERAL   = 3'd4,
        PH_SKIP      = 3'd5,
        PH_DONE      = 3'd6
    } t_phase;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [RUN_W-1:0] run_length;
        logic             line_done;
        logic             image_done;
        logic             last_of_item;
    } t_run;

    // results produced by one accepted byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        t_run       first;
        t_run       second;
    } t_push;

endpackage

/* sv/srle_byte_if.sv */
`timescale 1ns / 1ps

interface srle_byte_if;
    logic                      valid;
    logic                      ready;
    logic [srle_pkg::PIX_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

/* sv/srle_run_if.sv */
`timescale 1ns / 1ps

interface srle_run_if;
    logic                      valid;
    logic                      ready;
    logic [srle_pkg::PIX_W-1:0] pixel;
    logic [srle_pkg::RUN_W-1:0] run_length;
    logic                      line_done;
    logic                      image_done;
    logic                      last_of_item;

    modport source (output valid, output pixel, output run_length, output line_done,
                    output image_done, output last_of_item, input ready);
    modport sink   (input valid, input pixel, input run_length, input line_done,
                    input image_done, input last_of_item, output ready);
endinterface

/* sv/scanline_rle_image_decoder_core.sv */
`timescale 1ns / 1ps

// Scanline run-length decoder. The compressed image body (file header already
// removed) enters one byte per transaction on i_byte. Each line is a
// little-endian 16-bit byte count followed by packets: 0x81..0xFF repeats the
// next byte, 0x01..0x7F copies literal bytes, 0x00/0x80 ends the line early.
// Decoded pixels leave on o_run as run descriptors (pixel, run_length) clipped
// to line_width; every line closes with a padding run that carries line_done,
// and image_done on the final line. Bytes after the final line are swallowed.
//
// Throughput: one byte per cycle while i_byte.ready is high. Each result is
// registered in the output queue (one register stage) before it shows on
// o_run. A byte yields at most two results, so the queue fills when
// o_run drains slower than one per cycle; i_byte.ready drops while more than
// two entries wait and rises again as soon as the receiver takes them. A
// stalled receiver loses nothing.
//
// Reset (synchronous, active low) empties the queue, returns the parser to
// the length-low byte of line zero and loads line_width = 320, line_total = 200.
// Write registers through i_cfg_* only while the block is idle.
module scanline_rle_image_decoder_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    srle_byte_if.sink                   i_byte,
    srle_run_if.source                  o_run,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [srle_pkg::CFG_W-1:0]  i_cfg_wdata
);

    // cap the width limit to what the 13-bit register can express
    localparam logic [srle_pkg::RUN_W-1:0] WIDTH_CAP =
        (MAX_WIDTH > 8191) ? 13'h1FFF : srle_pkg::RUN_W'(MAX_WIDTH);

    logic [srle_pkg::CFG_W-1:0] r_line_width;
    logic [srle_pkg::CFG_W-1:0] r_line_total;
    logic [srle_pkg::RUN_W-1:0] eff_width;
    logic                       accept;
    logic                       q_room;
    logic                       q_valid;
    srle_pkg::t_run             q_head;
    srle_pkg::t_push            push;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= 13'd320;
            r_line_total <= 13'd200;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srle_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_wdata;
                srle_pkg::CFG_LINE_TOTAL: r_line_total <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign eff_width = (r_line_width < WIDTH_CAP) ? r_line_width : WIDTH_CAP;

    // advance the parser on every input transaction
    assign i_byte.ready = q_room;
    assign accept       = i_byte.valid && q_room;

    srle_dec u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_byte.data_byte),
        .i_eff_width (eff_width),
        .i_line_total(r_line_total),
        .o_push      (push)
    );

    // hold results until the receiver takes them
    srle_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_run.ready),
        .o_room  (q_room),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    assign o_run.valid        = q_valid;
    assign o_run.pixel        = q_head.pixel;
    assign o_run.run_length   = q_head.run_length;
    assign o_run.line_done    = q_head.line_done;
    assign o_run.image_done   = q_head.image_done;
    assign o_run.last_of_item = q_head.last_of_item;

    // input stalls only while results are waiting
    a_stall_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_room |-> q_valid)
        else $error("input stalled with empty output queue");

    // a transaction that produces results shows one on the next cycle
    a_result_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count != 2'd0) |=> q_valid)
        else $error("produced result not presented");

    // a byte with two results is a pixel run followed by the line end
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count == 2'd2) |-> (push.second.line_done && !push.first.line_done
                                  && !push.first.last_of_item))
        else $error("two-result transaction out of order");

    // image end only comes with a line end
    a_image_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_head.image_done) |-> q_head.line_done)
        else $error("image_done without line_done");

endmodule

/* sv/srle_dec.sv */
`timescale 1ns / 1ps

module srle_dec (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [srle_pkg::PIX_W-1:0]  i_data_byte,
    input  logic [srle_pkg::RUN_W-1:0]  i_eff_width,
    input  logic [srle_pkg::CFG_W-1:0]  i_line_total,
    output srle_pkg::t_push             o_push
);

    srle_pkg::t_phase              r_phase,       n_phase;
    logic [srle_pkg::PIX_W-1:0]    r_len_lo,      n_len_lo;
    logic [srle_pkg::LEN_W-1:0]    r_bytes_left,  n_bytes_left;
    logic [srle_pkg::CNT_W-1:0]    r_lit_left,    n_lit_left;
    logic [srle_pkg::CNT_W-1:0]    r_run_count,   n_run_count;
    logic [srle_pkg::RUN_W-1:0]    r_column,      n_column;
    logic [srle_pkg::CFG_W-1:0]    r_line_index,  n_line_index;

    logic                          finished;
    logic [srle_pkg::LEN_W-1:0]    bytes_dec;
    logic [srle_pkg::LEN_W-1:0]    len_new;
    logic [srle_pkg::RUN_W-1:0]    col_base;
    logic [srle_pkg::RUN_W-1:0]    room;
    logic [srle_pkg::RUN_W-1:0]    want;
    logic [srle_pkg::RUN_W-1:0]    take;
    logic [srle_pkg::RUN_W-1:0]    pad;
    logic [srle_pkg::CFG_W-1:0]    index_inc;
    logic                          is_last;
    logic                          emit_px;
    logic                          end_ln;
    logic                          skip_rest;
    logic [srle_pkg::CNT_W-1:0]    lit_dec;

    assign finished  = (r_phase == srle_pkg::PH_DONE) || (r_line_index >= i_line_total);
    assign emit_px   = !finished && (r_phase == srle_pkg::PH_RUN_VALUE ||
                                     r_phase == srle_pkg::PH_LITERAL);
    assign bytes_dec = r_bytes_left - 16'd1;
    assign len_new   = {i_data_byte, r_len_lo};
    assign col_base  = (r_phase == srle_pkg::PH_LEN_HI) ? '0 : r_column;
    assign room      = (i_eff_width > col_base) ? i_eff_width - col_base : '0;
    assign want      = (r_phase == srle_pkg::PH_RUN_VALUE) ?
                       {{(srle_pkg::RUN_W-srle_pkg::CNT_W){1'b0}}, r_run_count} :
                       {{(srle_pkg::RUN_W-1){1'b0}}, 1'b1};
    assign take      = emit_px ? ((want < room) ? want : room) : '0;
    assign pad       = room - take;
    assign index_inc = r_line_index + 13'd1;
    assign is_last   = index_inc >= i_line_total;
    assign lit_dec   = (r_lit_left != '0) ? r_lit_left - 7'd1 : r_lit_left;

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_len_lo     = r_len_lo;
        n_bytes_left = r_bytes_left;
        n_lit_left   = r_lit_left;
        n_run_count  = r_run_count;
        n_column     = r_column;
        n_line_index = r_line_index;
        end_ln       = 1'b0;
        skip_rest    = 1'b0;
        if (finished) begin
            n_phase = srle_pkg::PH_DONE;
        end else begin
            case (r_phase)
                srle_pkg::PH_LEN_LO: begin
                    n_len_lo = i_data_byte;
                    n_phase  = srle_pkg::PH_LEN_HI;
                end
                srle_pkg::PH_LEN_HI: begin
                    n_bytes_left = len_new;
                    n_column     = '0;
                    if (len_new == '0) end_ln = 1'b1;
                    else               n_phase = srle_pkg::PH_HEADER;
                end
                srle_pkg::PH_HEADER: begin
                    n_bytes_left = bytes_dec;
                    if (i_data_byte == '0 || i_data_byte == srle_pkg::PKT_MARK) begin
                        end_ln    = 1'b1;
                        skip_rest = 1'b1;
                    end else if (i_data_byte[7]) begin
                        n_run_count = i_data_byte[6:0];
                        if (bytes_dec == '0) end_ln = 1'b1;
                        else                 n_phase = srle_pkg::PH_RUN_VALUE;
                    end else begin
                        n_lit_left = i_data_byte[6:0];
                        if (bytes_dec == '0) end_ln = 1'b1;
                        else                 n_phase = srle_pkg::PH_LITERAL;
                    end
                end
                srle_pkg::PH_RUN_VALUE: begin
                    n_bytes_left = bytes_dec;
                    n_column     = r_column + take;
                    n_run_count  = '0;
                    if (bytes_dec == '0) end_ln = 1'b1;
                    else                 n_phase = srle_pkg::PH_HEADER;
                end
                srle_pkg::PH_LITERAL: begin
                    n_bytes_left = bytes_dec;
                    n_column     = r_column + take;
                    n_lit_left   = lit_dec;
                    if (bytes_dec == '0)    end_ln = 1'b1;
                    else if (lit_dec == '0) n_phase = srle_pkg::PH_HEADER;
                end
                srle_pkg::PH_SKIP: begin
                    if (r_bytes_left != '0) n_bytes_left = bytes_dec;
                    if (r_bytes_left == '0 || bytes_dec == '0) n_phase = srle_pkg::PH_LEN_LO;
                end
                default: begin
                    n_phase = srle_pkg::PH_DONE;
                end
            endcase
            if (end_ln) begin
                n_line_index = index_inc;
                n_column     = '0;
                n_lit_left   = '0;
                n_run_count  = '0;
                if (is_last)                              n_phase = srle_pkg::PH_DONE;
                else if (skip_rest && bytes_dec != '0)    n_phase = srle_pkg::PH_SKIP;
                else                                      n_phase = srle_pkg::PH_LEN_LO;
            end
        end
    end

    // results
    always_comb begin
        srle_pkg::t_run px_res;
        srle_pkg::t_run end_res;
        px_res.pixel         = i_data_byte;
        px_res.run_length    = take;
        px_res.line_done     = 1'b0;
        px_res.image_done    = 1'b0;
        px_res.last_of_item  = !end_ln;
        end_res.pixel        = '0;
        end_res.run_length   = pad;
        end_res.line_done    = 1'b1;
        end_res.image_done   = is_last;
        end_res.last_of_item = 1'b1;
        o_push.first  = (emit_px && take != '0) ? px_res : end_res;
        o_push.second = end_res;
        if (!i_accept)                          o_push.count = 2'd0;
        else if (emit_px && take != '0)         o_push.count = end_ln ? 2'd2 : 2'd1;
        else                                    o_push.count = end_ln ? 2'd1 : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= srle_pkg::PH_LEN_LO;
            r_len_lo     <= '0;
            r_bytes_left <= '0;
            r_lit_left   <= '0;
            r_run_count  <= '0;
            r_column     <= '0;
            r_line_index <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_len_lo     <= n_len_lo;
            r_bytes_left <= n_bytes_left;
            r_lit_left   <= n_lit_left;
            r_run_count  <= n_run_count;
            r_column     <= n_column;
            r_line_index <= n_line_index;
        end
    end

endmodule

/* sv/srle_outq.sv */
`timescale 1ns / 1ps

module srle_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  srle_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_room,
    output logic            o_valid,
    output srle_pkg::t_run  o_head
);

    srle_pkg::t_run              r_slot [srle_pkg::Q_DEPTH];
    logic [srle_pkg::Q_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [srle_pkg::Q_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [srle_pkg::Q_AW:0]     r_count,  n_count;
    logic [srle_pkg::Q_AW-1:0]   wr_ptr_1;
    logic                        pop;

    assign pop      = i_pop && o_valid;
    assign wr_ptr_1 = r_wr_ptr + 1'b1;
    assign n_wr_ptr = r_wr_ptr + srle_pkg::Q_AW'(i_push.count);
    assign n_rd_ptr = r_rd_ptr + srle_pkg::Q_AW'(pop);
    assign n_count  = r_count + (srle_pkg::Q_AW+1)'(i_push.count)
                              - (srle_pkg::Q_AW+1)'(pop);

    // keep room for the worst case of two results per byte
    assign o_room  = r_count <= (srle_pkg::Q_AW+1)'(srle_pkg::Q_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_slot[r_wr_ptr] <= i_push.first;
        if (i_push.count == 2'd2) r_slot[wr_ptr_1] <= i_push.second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
